// File: sv/snc_pkg.sv
package snc_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int MAX_SAMPLES = 256;
    localparam int NUM_FEAT    = 4;
    localparam int FEAT_W      = 16;
    localparam int MEAN_W      = 16;
    localparam int VAR_W       = 32;
    localparam int DIST_W      = 32;

    localparam int CLS_W    = $clog2(NUM_CLASSES);
    localparam int FI_W     = $clog2(NUM_FEAT);
    localparam int KEY_W    = CLS_W + FI_W;
    localparam int NUM_KEYS = NUM_CLASSES * NUM_FEAT;
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = FEAT_W + $clog2(MAX_SAMPLES);
    localparam int SQ_W     = 2 * FEAT_W + $clog2(MAX_SAMPLES);

    // operand widths of the shared multiply/divide unit
    localparam int A_W    = SQ_W + CNT_W;
    localparam int B_W    = 32;
    localparam int STEP_W = $clog2(A_W + 1);

    localparam logic [DIST_W-1:0] START_MIN = 32'd100000000;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_TRAIN    = 2'd1;
    localparam logic [1:0] OP_FINAL    = 2'd2;
    localparam logic [1:0] OP_CLASSIFY = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LABEL = 3'd1;
    localparam logic [2:0] ST_UNUSABLE  = 3'd2;
    localparam logic [2:0] ST_NOT_FINAL = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TR_SQ,
        S_TR_ACC,
        S_FIN_CHK,
        S_FIN_MEAN,
        S_FIN_NQ,
        S_FIN_SS,
        S_FIN_NN,
        S_FIN_VAR,
        S_CL_CHK,
        S_CL_SQ,
        S_CL_TERM,
        S_WAIT,
        S_DONE
    } state_t;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } mdu_op_t;

    typedef struct packed {
        logic           start;
        mdu_op_t        op;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
    } mdu_req_t;

    typedef struct packed {
        logic           done;
        logic [A_W-1:0] result;
    } mdu_rsp_t;

endpackage

// File: sv/standardized_nearest_centroid.sv
// Standardized nearest-centroid classifier over four unsigned Q8.8 features. Items carry an
// opcode: clear, train, finalize or classify, and each item yields exactly one result. The
// block takes one item at a time and is stalled while it works; a finished result waits in an
// output register, so the next item can be taken before it is read. All multiplies and
// divides go through one bit-serial multiply/divide unit. Train does four squarings; finalize,
// per class and feature, a mean divide, three multiplies and, where the variance is positive,
// a variance divide; classify, per class and feature, a square and a divide.
module standardized_nearest_centroid
    import snc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [FEAT_W-1:0] feature_a,
    input  logic [FEAT_W-1:0] feature_b,
    input  logic [FEAT_W-1:0] feature_c,
    input  logic [FEAT_W-1:0] feature_d,
    input  logic [1:0]        class_label,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        predicted_class,
    output logic              matches_label,
    output logic [DIST_W-1:0] best_distance,
    output logic [2:0]        status
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [CNT_W-1:0]  class_count_reg [NUM_CLASSES];
    logic              finalized_reg, finalized_set, finalized_clr;
    logic              cnt_clr, cnt_inc;
    logic              out_valid_reg, out_valid_next;

    logic [SUM_W-1:0]  feature_sum_reg [NUM_KEYS];
    logic [SQ_W-1:0]   feature_square_sum_reg [NUM_KEYS];
    logic [MEAN_W-1:0] class_mean_reg [NUM_KEYS];
    logic [VAR_W-1:0]  class_variance_reg [NUM_KEYS];
    logic              sum_we, mean_we, var_we;
    logic [SUM_W-1:0]  sum_wdata;
    logic [SQ_W-1:0]   sq_wdata;
    logic [MEAN_W-1:0] mean_wdata;
    logic [VAR_W-1:0]  var_wdata;

    logic [1:0]        op_reg, op_next;
    logic [FEAT_W-1:0] x_reg [NUM_FEAT];
    logic [FEAT_W-1:0] x_in [NUM_FEAT];
    logic              x_load;
    logic [1:0]        label_reg, label_next;
    logic [CLS_W-1:0]  c_reg, c_next;
    logic [FI_W-1:0]   f_reg, f_next;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [1:0]        bi_reg, bi_next;
    logic              flag_reg, flag_next;
    logic [2:0]        st_reg, st_next;
    logic [A_W-1:0]    t1_reg, t1_next;
    logic [A_W-1:0]    t2_reg, t2_next;

    logic [1:0]        pred_out_reg, pred_out_next;
    logic              match_out_reg, match_out_next;
    logic [DIST_W-1:0] dist_out_reg, dist_out_next;
    logic [2:0]        status_out_reg, status_out_next;

    mdu_req_t mdu_req;
    mdu_rsp_t mdu_rsp;

    logic              in_fire, out_free;
    logic              in_lbl_ok, in_lbl_full, lbl_bad;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt_cur;
    logic [FEAT_W-1:0] x_cur;
    logic [MEAN_W-1:0] m_cur;
    logic [VAR_W-1:0]  v_cur;
    logic [FEAT_W-1:0] dev;
    logic              last_f, last_c, fin_last, cl_skip, var_gt;
    logic [VAR_W-1:0]  var_sat;
    logic [A_W:0]      acc_sum;
    logic [DIST_W-1:0] acc_sat;
    logic              is_cls;

    snc_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .rsp   (mdu_rsp)
    );

    assign x_in[0] = feature_a;
    assign x_in[1] = feature_b;
    assign x_in[2] = feature_c;
    assign x_in[3] = feature_d;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !(out_valid_reg && out_stall);

    assign in_lbl_ok   = {1'b0, class_label} < 3'(NUM_CLASSES);
    assign in_lbl_full = class_count_reg[class_label[CLS_W-1:0]] >= CNT_W'(MAX_SAMPLES);
    assign lbl_bad     = {1'b0, label_reg} >= 3'(NUM_CLASSES);

    assign key     = {c_reg, f_reg};
    assign cnt_cur = class_count_reg[c_reg];
    assign x_cur   = x_reg[f_reg];
    assign m_cur   = class_mean_reg[key];
    assign v_cur   = class_variance_reg[key];
    assign dev     = (x_cur >= m_cur) ? (x_cur - m_cur) : (m_cur - x_cur);

    assign last_f   = (f_reg == FI_W'(NUM_FEAT - 1));
    assign last_c   = (c_reg == CLS_W'(NUM_CLASSES - 1));
    assign fin_last = last_f && last_c;
    assign cl_skip  = (cnt_cur == '0) || (v_cur == '0);
    assign var_gt   = t1_reg > t2_reg;
    assign var_sat  = (|mdu_rsp.result[A_W-1:VAR_W]) ? '1 : mdu_rsp.result[VAR_W-1:0];
    assign acc_sum  = {1'b0, (A_W)'(acc_reg)} + {1'b0, mdu_rsp.result};
    assign acc_sat  = (|acc_sum[A_W:DIST_W]) ? '1 : acc_sum[DIST_W-1:0];
    assign is_cls   = (op_reg == OP_CLASSIFY) && (st_reg != ST_NOT_FINAL);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (opcode)
                        OP_CLEAR: state_next = S_DONE;
                        OP_TRAIN: state_next = (in_lbl_ok && !in_lbl_full) ? S_TR_SQ : S_DONE;
                        OP_FINAL: state_next = S_FIN_CHK;
                        default:  state_next = finalized_reg ? S_CL_CHK : S_DONE;
                    endcase
                end
            end
            S_TR_SQ:    state_next = S_WAIT;
            S_TR_ACC:   state_next = last_f ? S_DONE : S_TR_SQ;
            S_FIN_CHK:
            begin
                if (cnt_cur == '0)
                begin
                    state_next = fin_last ? S_DONE : S_FIN_CHK;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_FIN_MEAN: state_next = S_WAIT;
            S_FIN_NQ:   state_next = S_WAIT;
            S_FIN_SS:   state_next = S_WAIT;
            S_FIN_NN:
            begin
                if (var_gt)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = fin_last ? S_DONE : S_FIN_CHK;
                end
            end
            S_FIN_VAR:  state_next = fin_last ? S_DONE : S_FIN_CHK;
            S_CL_CHK:
            begin
                if (cl_skip)
                begin
                    state_next = last_c ? S_DONE : S_CL_CHK;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_CL_SQ:    state_next = S_WAIT;
            S_CL_TERM:  state_next = (last_f && last_c) ? S_DONE : S_CL_CHK;
            S_WAIT:     state_next = mdu_rsp.done ? ret_reg : S_WAIT;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and unit requests
    always_comb
    begin
        ret_next        = ret_reg;
        op_next         = op_reg;
        label_next      = label_reg;
        c_next          = c_reg;
        f_next          = f_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        bi_next         = bi_reg;
        flag_next       = flag_reg;
        st_next         = st_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        x_load          = 1'b0;
        cnt_clr         = 1'b0;
        cnt_inc         = 1'b0;
        finalized_set   = 1'b0;
        finalized_clr   = 1'b0;
        sum_we          = 1'b0;
        mean_we         = 1'b0;
        var_we          = 1'b0;
        sum_wdata       = '0;
        sq_wdata        = '0;
        mean_wdata      = '0;
        var_wdata       = '0;
        mdu_req         = '0;
        mdu_req.op      = MDU_MUL;
        out_valid_next  = out_valid_reg && out_stall;
        pred_out_next   = pred_out_reg;
        match_out_next  = match_out_reg;
        dist_out_next   = dist_out_reg;
        status_out_next = status_out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    x_load     = 1'b1;
                    op_next    = opcode;
                    label_next = class_label;
                    c_next     = (opcode == OP_TRAIN) ? class_label[CLS_W-1:0] : '0;
                    f_next     = '0;
                    acc_next   = '0;
                    best_next  = START_MIN;
                    bi_next    = '0;
                    flag_next  = 1'b0;
                    st_next    = ST_OK;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            cnt_clr       = 1'b1;
                            finalized_clr = 1'b1;
                        end
                        OP_TRAIN:
                        begin
                            if (!in_lbl_ok)
                            begin
                                st_next = ST_BAD_LABEL;
                            end
                            else if (in_lbl_full)
                            begin
                                st_next = ST_OVERFLOW;
                            end
                        end
                        OP_FINAL: st_next = ST_OK;
                        default:
                        begin
                            if (!finalized_reg)
                            begin
                                st_next = ST_NOT_FINAL;
                            end
                        end
                    endcase
                end
            end
            S_TR_SQ:
            begin
                mdu_req.start = 1'b1;
                mdu_req.op    = MDU_MUL;
                mdu_req.a     = A_W'(x_cur);
                mdu_req.b     = B_W'(x_cur);
                ret_next      = S_TR_ACC;
            end
            S_TR_ACC:
            begin
                // an empty class holds stale sums, so its first sample overwrites them
                sum_we    = 1'b1;
                sum_wdata = ((cnt_cur == '0) ? '0 : feature_sum_reg[key]) + SUM_W'(x_cur);
                sq_wdata  = ((cnt_cur == '0) ? '0 : feature_square_sum_reg[key])
                            + mdu_rsp.result[SQ_W-1:0];
                if (last_f)
                begin
                    cnt_inc       = 1'b1;
                    finalized_clr = 1'b1;
                end
                else
                begin
                    f_next = f_reg + 1'b1;
                end
            end
            S_FIN_CHK:
            begin
                if (cnt_cur == '0)
                begin
                    mean_we   = 1'b1;
                    var_we    = 1'b1;
                    flag_next = 1'b1;
                    f_next    = f_reg + 1'b1;
                    if (last_f && !last_c)
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_DIV;
                    mdu_req.a     = A_W'(feature_sum_reg[key]);
                    mdu_req.b     = B_W'(cnt_cur);
                    ret_next      = S_FIN_MEAN;
                end
            end
            S_FIN_MEAN:
            begin
                mean_we       = 1'b1;
                mean_wdata    = mdu_rsp.result[MEAN_W-1:0];
                mdu_req.start = 1'b1;
                mdu_req.op    = MDU_MUL;
                mdu_req.a     = A_W'(feature_square_sum_reg[key]);
                mdu_req.b     = B_W'(cnt_cur);
                ret_next      = S_FIN_NQ;
            end
            S_FIN_NQ:
            begin
                t1_next       = mdu_rsp.result;
                mdu_req.start = 1'b1;
                mdu_req.op    = MDU_MUL;
                mdu_req.a     = A_W'(feature_sum_reg[key]);
                mdu_req.b     = B_W'(feature_sum_reg[key]);
                ret_next      = S_FIN_SS;
            end
            S_FIN_SS:
            begin
                t2_next       = mdu_rsp.result;
                mdu_req.start = 1'b1;
                mdu_req.op    = MDU_MUL;
                mdu_req.a     = A_W'(cnt_cur);
                mdu_req.b     = B_W'(cnt_cur);
                ret_next      = S_FIN_NN;
            end
            S_FIN_NN:
            begin
                if (var_gt)
                begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_DIV;
                    mdu_req.a     = t1_reg - t2_reg;
                    mdu_req.b     = mdu_rsp.result[B_W-1:0];
                    ret_next      = S_FIN_VAR;
                end
                else
                begin
                    var_we    = 1'b1;
                    flag_next = 1'b1;
                    f_next    = f_reg + 1'b1;
                    if (last_f && !last_c)
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_FIN_VAR:
            begin
                var_we    = 1'b1;
                var_wdata = var_sat;
                if (var_sat == '0)
                begin
                    flag_next = 1'b1;
                end
                f_next = f_reg + 1'b1;
                if (last_f && !last_c)
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            S_CL_CHK:
            begin
                if (cl_skip)
                begin
                    flag_next = 1'b1;
                    f_next    = '0;
                    acc_next  = '0;
                    if (!last_c)
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_MUL;
                    mdu_req.a     = A_W'(dev);
                    mdu_req.b     = B_W'(dev);
                    ret_next      = S_CL_SQ;
                end
            end
            S_CL_SQ:
            begin
                mdu_req.start = 1'b1;
                mdu_req.op    = MDU_DIV;
                mdu_req.a     = A_W'({mdu_rsp.result[2*FEAT_W-1:0], 8'b0});
                mdu_req.b     = B_W'(v_cur);
                ret_next      = S_CL_TERM;
            end
            S_CL_TERM:
            begin
                if (last_f)
                begin
                    // strictly smaller wins, so ties keep the lower class
                    if (acc_sat < best_reg)
                    begin
                        best_next = acc_sat;
                        bi_next   = 2'(c_reg);
                    end
                    f_next   = '0;
                    acc_next = '0;
                    if (!last_c)
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    acc_next = acc_sat;
                    f_next   = f_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_FINAL)
                    begin
                        finalized_set   = 1'b1;
                        status_out_next = flag_reg ? ST_UNUSABLE : ST_OK;
                    end
                    else if (is_cls)
                    begin
                        status_out_next = flag_reg ? ST_UNUSABLE
                                        : (lbl_bad ? ST_BAD_LABEL : ST_OK);
                    end
                    else
                    begin
                        status_out_next = st_reg;
                    end
                    pred_out_next  = is_cls ? bi_reg : '0;
                    match_out_next = is_cls && (bi_reg == label_reg);
                    dist_out_next  = is_cls ? best_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            finalized_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                class_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            if (finalized_set)
            begin
                finalized_reg <= 1'b1;
            end
            else if (finalized_clr)
            begin
                finalized_reg <= 1'b0;
            end
            if (cnt_clr)
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    class_count_reg[i] <= '0;
                end
            end
            else if (cnt_inc)
            begin
                class_count_reg[c_reg] <= cnt_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        label_reg      <= label_next;
        c_reg          <= c_next;
        f_reg          <= f_next;
        acc_reg        <= acc_next;
        best_reg       <= best_next;
        bi_reg         <= bi_next;
        flag_reg       <= flag_next;
        st_reg         <= st_next;
        t1_reg         <= t1_next;
        t2_reg         <= t2_next;
        pred_out_reg   <= pred_out_next;
        match_out_reg  <= match_out_next;
        dist_out_reg   <= dist_out_next;
        status_out_reg <= status_out_next;
        if (x_load)
        begin
            for (int i = 0; i < NUM_FEAT; i++)
            begin
                x_reg[i] <= x_in[i];
            end
        end
        if (sum_we)
        begin
            feature_sum_reg[key]        <= sum_wdata;
            feature_square_sum_reg[key] <= sq_wdata;
        end
        if (mean_we)
        begin
            class_mean_reg[key] <= mean_wdata;
        end
        if (var_we)
        begin
            class_variance_reg[key] <= var_wdata;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_class = pred_out_reg;
    assign matches_label   = match_out_reg;
    assign best_distance   = dist_out_reg;
    assign status          = status_out_reg;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("item taken but sequencer stayed idle");

    a_unit_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_rsp.done |-> state_reg == S_WAIT)
        else $error("unit finished while sequencer was not waiting");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished item did not reach the output register");
`endif

endmodule

// File: sv/snc_mdu.sv
module snc_mdu
    import snc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mdu_req_t req,
    output mdu_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    mdu_op_t           op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [A_W-1:0]    a_reg, a_next;
    logic [B_W-1:0]    b_reg, b_next;
    logic [A_W-1:0]    p_reg, p_next;
    logic [B_W-1:0]    r_reg, r_next;

    logic [B_W:0] trial;
    logic [B_W:0] diff;
    logic         ge;

    // restoring division: one quotient bit a cycle, quotient shifts into a_reg
    assign trial = {r_reg, a_reg[A_W-1]};
    assign diff  = trial - {1'b0, b_reg};
    assign ge    = trial >= {1'b0, b_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        step_next = step_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            step_next = STEP_W'(A_W);
            a_next    = req.a;
            b_next    = req.b;
            p_next    = '0;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == MDU_MUL)
            begin
                // shift-add, stops once the multiplier runs out of ones
                if (b_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    if (b_reg[0])
                    begin
                        p_next = p_reg + a_reg;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            end
            else
            begin
                if (step_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    r_next    = ge ? diff[B_W-1:0] : trial[B_W-1:0];
                    a_next    = {a_reg[A_W-2:0], ge};
                    step_next = step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= MDU_MUL;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
        r_reg <= r_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == MDU_MUL) ? p_reg : a_reg;

endmodule
